// ----- design/open_addressing_hash_map_assert.svh -----
// Assertion macros shared by the hash map checker
`ifndef OPEN_ADDRESSING_HASH_MAP_ASSERT_SVH
`define OPEN_ADDRESSING_HASH_MAP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define OAHM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define OAHM_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/oahm_pkg.sv -----
// Shared constants, codes and tables of the open-addressing hash map
`timescale 1ns / 1ps
`default_nettype none
package oahm_pkg;

    localparam int MAX_SHIFT_DEF = 10;
    localparam int KEY_BYTES_DEF = 8;
    localparam int MIN_SHIFT     = 3;
    localparam int SHW           = 5;
    localparam int PRIME_W       = 17;

    localparam logic [31:0] HASH_SEED  = 32'd5381;
    localparam logic [31:0] HASH_EMPTY = 32'd0;
    localparam logic [31:0] HASH_TOMB  = 32'd1;
    localparam logic [31:0] HASH_MIN   = 32'd2;

    localparam logic [2:0] FUNC_INSERT  = 3'd0;
    localparam logic [2:0] FUNC_REPLACE = 3'd1;
    localparam logic [2:0] FUNC_ADD     = 3'd2;
    localparam logic [2:0] FUNC_REMOVE  = 3'd3;
    localparam logic [2:0] FUNC_LOOKUP  = 3'd4;
    localparam logic [2:0] FUNC_CLEAR   = 3'd5;

    // result item layout in m_tdata
    localparam int M_HIT_BIT    = 0;
    localparam int M_VAL_LO     = 1;
    localparam int M_VAL_HI     = 64;
    localparam int M_STATUS_BIT = 65;
    localparam int M_CNT_LO     = 66;
    localparam int M_CNT_HI     = 76;
    localparam int M_CAP_LO     = 77;
    localparam int M_CAP_HI     = 87;
    localparam int M_DATA_W     = 88;

    // largest prime below each power of two, for shifts 2 to 16
    function automatic logic [PRIME_W-1:0] prime_for(input logic [SHW-1:0] shift);
        logic [PRIME_W-1:0] p;
        case (shift)
            5'd0:    p = 17'd1;
            5'd1:    p = 17'd2;
            5'd2:    p = 17'd3;
            5'd3:    p = 17'd7;
            5'd4:    p = 17'd13;
            5'd5:    p = 17'd31;
            5'd6:    p = 17'd61;
            5'd7:    p = 17'd127;
            5'd8:    p = 17'd251;
            5'd9:    p = 17'd509;
            5'd10:   p = 17'd1021;
            5'd11:   p = 17'd2039;
            5'd12:   p = 17'd4093;
            5'd13:   p = 17'd8191;
            5'd14:   p = 17'd16381;
            5'd15:   p = 17'd32749;
            5'd16:   p = 17'd65521;
            default: p = 17'd1;
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

// ----- design/open_addressing_hash_map.sv -----
// Open-addressing hash map with djb2 keys, triangular probing and two-bank rehash
//
//  channel | dir | tdata                          | tuser | item
//  s_      | in  | key[63:0], value[127:64]       | func  | one operation
//  m_      | out | hit, value_out, status,        | -     | one result
//          |     | entry_count, capacity          |       |
//
// Each item is accepted, hashed byte by byte and reduced by a restoring prime remainder,
// then probed through the single-read-port bucket memory; an action step and the result follow.
// A fresh empty slot or a remove adds a load check; a resize clears the new bank, then
// reads each old bucket and rehashes each live one by divider and probe. Clear sweeps size.
// After reset a clearing pass over the minimum-size table runs before the first item.
// A result waiting on m_ holds back the end of the next item only.
`timescale 1ns / 1ps
`default_nettype none
module open_addressing_hash_map #(
    parameter int MAX_SHIFT = oahm_pkg::MAX_SHIFT_DEF,
    parameter int KEY_BYTES = oahm_pkg::KEY_BYTES_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,   // key [63:0], value [127:64]
    input  wire logic [2:0]   s_tuser,   // func [2:0]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [oahm_pkg::M_DATA_W-1:0] m_tdata // hit, value_out[64:1], status,
                                                  // entry_count[76:66], capacity[87:77]
);

    localparam int IW    = MAX_SHIFT;
    localparam int AW    = MAX_SHIFT + 1;
    localparam int DEPTH = 1 << AW;
    localparam int CW    = MAX_SHIFT + 1;
    localparam int WW    = CW + 3;
    localparam int SHW   = oahm_pkg::SHW;
    localparam int PW    = oahm_pkg::PRIME_W;

    typedef enum logic [4:0] {
        ST_INIT, ST_IDLE, ST_HASH, ST_DIV, ST_PRD, ST_PCK, ST_ACT, ST_RSZ, ST_CLR,
        ST_RCLR, ST_RRD, ST_RCHK, ST_RPRD, ST_RPCK, ST_OUT
    } state_t;

    state_t state_reg;

    logic [31:0]      hash_mem [DEPTH];
    logic [63:0]      key_mem  [DEPTH];
    logic [63:0]      val_mem  [DEPTH];
    logic [31:0]      hash_rd_reg;
    logic [63:0]      key_rd_reg;
    logic [63:0]      val_rd_reg;

    logic [2:0]       func_reg;
    logic [63:0]      key_sh_reg;
    logic [63:0]      key_reg;
    logic [63:0]      val_reg;
    logic [31:0]      hash_reg;
    logic [3:0]       byte_cnt_reg;
    logic             key_end_reg;

    logic [4:0]       div_cnt_reg;
    logic [PW:0]      rem_reg;
    logic [31:0]      div_num_reg;
    logic [PW-1:0]    div_p_reg;
    logic             div_rh_reg;

    logic [IW-1:0]    idx_reg;
    logic [IW-1:0]    step_reg;
    logic [CW-1:0]    n_reg;
    logic             have_tomb_reg;
    logic [IW-1:0]    tomb_reg;
    logic             pr_hit_reg;
    logic             pr_empty_reg;
    logic [63:0]      hit_val_reg;

    logic [CW-1:0]    live_reg;
    logic [CW-1:0]    used_reg;
    logic [SHW-1:0]   shift_reg;
    logic [SHW-1:0]   new_shift_reg;
    logic             bank_reg;
    logic [CW-1:0]    sweep_reg;
    logic [CW-1:0]    old_i_reg;
    logic [31:0]      rh_hash_reg;
    logic [63:0]      rh_key_reg;
    logic [63:0]      rh_val_reg;

    logic             res_hit_reg;
    logic [63:0]      res_vout_reg;
    logic             res_status_reg;
    logic             m_tvalid_reg;
    logic [oahm_pkg::M_DATA_W-1:0] m_data_reg;

    logic [CW-1:0]    size;
    logic [IW-1:0]    mask;
    logic [CW-1:0]    nsize;
    logic [IW-1:0]    nmask;
    logic             old_last;
    logic [7:0]       cur_byte;
    logic             byte_live;
    logic [31:0]      hash_step;
    logic [31:0]      hash_fin;
    logic [PW:0]      div_t;
    logic [PW:0]      div_sub;
    logic             is_put;
    logic [63:0]      put_val;
    logic             key_match;
    logic [CW-1:0]    n_inc;
    logic [IW-1:0]    step_inc;
    logic             rsz_cond;
    logic [SHW-1:0]   rsz_shift;
    logic [SHW-1:0]   live_bits;
    logic [WW-1:0]    size_w;
    logic [WW-1:0]    used_w;

    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    wr_addr;
    logic             hash_we;
    logic             key_we;
    logic             val_we;
    logic [31:0]      hash_wd;
    logic [63:0]      key_wd;
    logic [63:0]      val_wd;

    assign size     = CW'(1) << shift_reg;
    assign mask     = IW'(size - CW'(1));
    assign nsize    = CW'(1) << new_shift_reg;
    assign nmask    = IW'(nsize - CW'(1));
    assign old_last = (old_i_reg == size - CW'(1));
    assign n_inc    = n_reg + CW'(1);
    assign step_inc = step_reg + IW'(1);

    assign cur_byte  = key_sh_reg[7:0];
    assign byte_live = !key_end_reg && (32'(byte_cnt_reg) < KEY_BYTES) && (cur_byte != 8'd0);
    assign hash_step = byte_live
                     ? (hash_reg << 5) + hash_reg + {{24{cur_byte[7]}}, cur_byte}
                     : hash_reg;
    assign hash_fin  = (hash_step < oahm_pkg::HASH_MIN) ? oahm_pkg::HASH_MIN : hash_step;

    // one restoring remainder step per cycle
    assign div_t   = {rem_reg[PW-1:0], div_num_reg[31]};
    assign div_sub = (div_t >= {1'b0, div_p_reg}) ? div_t - {1'b0, div_p_reg} : div_t;

    assign is_put    = (func_reg == oahm_pkg::FUNC_INSERT) || (func_reg == oahm_pkg::FUNC_REPLACE)
                    || (func_reg == oahm_pkg::FUNC_ADD);
    assign put_val   = (func_reg == oahm_pkg::FUNC_ADD) ? key_reg : val_reg;
    assign key_match = (hash_rd_reg == hash_reg) && (key_rd_reg == key_reg);

    // grow or shrink check and target shift
    always_comb begin
        live_bits = '0;
        for (int i = 0; i < CW; i++) begin
            if (live_reg[i]) begin
                live_bits = SHW'(i + 1);
            end
        end
        rsz_shift = (live_reg == '0) ? SHW'(0) : live_bits + SHW'(1);
        if (rsz_shift < SHW'(oahm_pkg::MIN_SHIFT)) begin
            rsz_shift = SHW'(oahm_pkg::MIN_SHIFT);
        end
        if (rsz_shift > SHW'(MAX_SHIFT)) begin
            rsz_shift = SHW'(MAX_SHIFT);
        end
        size_w   = WW'(size);
        used_w   = WW'(used_reg) + WW'(used_reg >> 4);
        rsz_cond = ((size_w > (WW'(live_reg) << 2)) && (shift_reg > SHW'(oahm_pkg::MIN_SHIFT)))
                || (size_w <= used_w);
    end

    always_comb begin
        case (state_reg)
            ST_PRD:  rd_addr = {bank_reg, idx_reg};
            ST_RRD:  rd_addr = {bank_reg, old_i_reg[IW-1:0]};
            ST_RPRD: rd_addr = {~bank_reg, idx_reg};
            default: rd_addr = '0;
        endcase
    end

    always_comb begin
        hash_we = 1'b0;
        key_we  = 1'b0;
        val_we  = 1'b0;
        wr_addr = '0;
        hash_wd = oahm_pkg::HASH_EMPTY;
        key_wd  = key_reg;
        val_wd  = put_val;
        case (state_reg)
            ST_INIT: begin
                hash_we = 1'b1;
                wr_addr = {1'b0, sweep_reg[IW-1:0]};
            end
            ST_CLR: begin
                hash_we = 1'b1;
                wr_addr = {bank_reg, sweep_reg[IW-1:0]};
            end
            ST_RCLR: begin
                hash_we = 1'b1;
                wr_addr = {~bank_reg, sweep_reg[IW-1:0]};
            end
            ST_RPCK: begin
                if (hash_rd_reg == oahm_pkg::HASH_EMPTY) begin
                    hash_we = 1'b1;
                    key_we  = 1'b1;
                    val_we  = 1'b1;
                    wr_addr = {~bank_reg, idx_reg};
                    hash_wd = rh_hash_reg;
                    key_wd  = rh_key_reg;
                    val_wd  = rh_val_reg;
                end
            end
            ST_ACT: begin
                if (is_put) begin
                    if (pr_hit_reg) begin
                        val_we  = 1'b1;
                        wr_addr = {bank_reg, idx_reg};
                    end else if (have_tomb_reg || pr_empty_reg) begin
                        hash_we = 1'b1;
                        key_we  = 1'b1;
                        val_we  = 1'b1;
                        wr_addr = {bank_reg, have_tomb_reg ? tomb_reg : idx_reg};
                        hash_wd = hash_reg;
                    end
                end else if (func_reg == oahm_pkg::FUNC_REMOVE && pr_hit_reg) begin
                    hash_we = 1'b1;
                    wr_addr = {bank_reg, idx_reg};
                    hash_wd = oahm_pkg::HASH_TOMB;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (hash_we) begin
            hash_mem[wr_addr] <= hash_wd;
        end
        if (key_we) begin
            key_mem[wr_addr] <= key_wd;
        end
        if (val_we) begin
            val_mem[wr_addr] <= val_wd;
        end
        hash_rd_reg <= hash_mem[rd_addr];
        key_rd_reg  <= key_mem[rd_addr];
        val_rd_reg  <= val_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            sweep_reg    <= '0;
            live_reg     <= '0;
            used_reg     <= '0;
            shift_reg    <= SHW'(oahm_pkg::MIN_SHIFT);
            bank_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != ST_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_INIT: begin
                    sweep_reg <= sweep_reg + CW'(1);
                    if (sweep_reg == CW'((1 << oahm_pkg::MIN_SHIFT) - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_tvalid) begin
                        func_reg       <= s_tuser;
                        key_sh_reg     <= s_tdata[63:0];
                        val_reg        <= s_tdata[127:64];
                        hash_reg       <= oahm_pkg::HASH_SEED;
                        byte_cnt_reg   <= '0;
                        key_end_reg    <= 1'b0;
                        res_hit_reg    <= 1'b0;
                        res_vout_reg   <= '0;
                        res_status_reg <= 1'b0;
                        state_reg      <= ST_HASH;
                    end
                end
                ST_HASH: begin
                    key_reg      <= {byte_live ? cur_byte : 8'd0, key_reg[63:8]};
                    key_sh_reg   <= key_sh_reg >> 8;
                    key_end_reg  <= !byte_live;
                    byte_cnt_reg <= byte_cnt_reg + 4'd1;
                    hash_reg     <= (byte_cnt_reg == 4'd7) ? hash_fin : hash_step;
                    if (byte_cnt_reg == 4'd7) begin
                        if (func_reg <= oahm_pkg::FUNC_LOOKUP) begin
                            div_num_reg <= hash_fin;
                            div_p_reg   <= oahm_pkg::prime_for(shift_reg);
                            rem_reg     <= '0;
                            div_cnt_reg <= '0;
                            div_rh_reg  <= 1'b0;
                            state_reg   <= ST_DIV;
                        end else if (func_reg == oahm_pkg::FUNC_CLEAR) begin
                            sweep_reg <= '0;
                            state_reg <= (live_reg != '0) ? ST_CLR : ST_RSZ;
                        end else begin
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_DIV: begin
                    rem_reg     <= div_sub;
                    div_num_reg <= div_num_reg << 1;
                    div_cnt_reg <= div_cnt_reg + 5'd1;
                    if (div_cnt_reg == 5'd31) begin
                        idx_reg       <= IW'(div_sub);
                        step_reg      <= '0;
                        n_reg         <= '0;
                        have_tomb_reg <= 1'b0;
                        pr_hit_reg    <= 1'b0;
                        pr_empty_reg  <= 1'b0;
                        state_reg     <= div_rh_reg ? ST_RPRD : ST_PRD;
                    end
                end
                ST_PRD: begin
                    state_reg <= ST_PCK;
                end
                ST_PCK: begin
                    if (hash_rd_reg == oahm_pkg::HASH_EMPTY) begin
                        pr_empty_reg <= 1'b1;
                        state_reg    <= ST_ACT;
                    end else if (key_match) begin
                        pr_hit_reg  <= 1'b1;
                        hit_val_reg <= val_rd_reg;
                        state_reg   <= ST_ACT;
                    end else begin
                        if (hash_rd_reg == oahm_pkg::HASH_TOMB && !have_tomb_reg) begin
                            have_tomb_reg <= 1'b1;
                            tomb_reg      <= idx_reg;
                        end
                        n_reg <= n_inc;
                        if (n_inc == size) begin
                            state_reg <= ST_ACT;
                        end else begin
                            step_reg  <= step_inc;
                            idx_reg   <= (idx_reg + step_inc) & mask;
                            state_reg <= ST_PRD;
                        end
                    end
                end
                ST_ACT: begin
                    if (is_put) begin
                        if (pr_hit_reg) begin
                            res_hit_reg <= 1'b1;
                            state_reg   <= ST_OUT;
                        end else if (have_tomb_reg) begin
                            live_reg  <= live_reg + CW'(1);
                            state_reg <= ST_OUT;
                        end else if (pr_empty_reg) begin
                            live_reg  <= live_reg + CW'(1);
                            used_reg  <= used_reg + CW'(1);
                            state_reg <= ST_RSZ;
                        end else begin
                            res_status_reg <= 1'b1;
                            state_reg      <= ST_OUT;
                        end
                    end else if (pr_hit_reg) begin
                        res_hit_reg <= 1'b1;
                        if (func_reg == oahm_pkg::FUNC_REMOVE) begin
                            live_reg  <= live_reg - CW'(1);
                            state_reg <= ST_RSZ;
                        end else begin
                            res_vout_reg <= hit_val_reg;
                            state_reg    <= ST_OUT;
                        end
                    end else begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_CLR: begin
                    sweep_reg <= sweep_reg + CW'(1);
                    if (sweep_reg == size - CW'(1)) begin
                        live_reg  <= '0;
                        used_reg  <= '0;
                        shift_reg <= SHW'(oahm_pkg::MIN_SHIFT);
                        state_reg <= ST_RSZ;
                    end
                end
                ST_RSZ: begin
                    if (rsz_cond) begin
                        new_shift_reg <= rsz_shift;
                        sweep_reg     <= '0;
                        state_reg     <= ST_RCLR;
                    end else begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_RCLR: begin
                    sweep_reg <= sweep_reg + CW'(1);
                    if (sweep_reg == nsize - CW'(1)) begin
                        old_i_reg <= '0;
                        state_reg <= ST_RRD;
                    end
                end
                ST_RRD: begin
                    state_reg <= ST_RCHK;
                end
                ST_RCHK, ST_RPCK: begin
                    if (state_reg == ST_RCHK && hash_rd_reg >= oahm_pkg::HASH_MIN) begin
                        rh_hash_reg <= hash_rd_reg;
                        rh_key_reg  <= key_rd_reg;
                        rh_val_reg  <= val_rd_reg;
                        div_num_reg <= hash_rd_reg;
                        div_p_reg   <= oahm_pkg::prime_for(new_shift_reg);
                        rem_reg     <= '0;
                        div_cnt_reg <= '0;
                        div_rh_reg  <= 1'b1;
                        state_reg   <= ST_DIV;
                    end else if (state_reg == ST_RPCK && hash_rd_reg != oahm_pkg::HASH_EMPTY
                                 && n_reg != nsize) begin
                        n_reg     <= n_inc;
                        step_reg  <= step_inc;
                        idx_reg   <= (idx_reg + step_inc) & nmask;
                        state_reg <= ST_RPRD;
                    end else if (old_last) begin
                        // rehash done: switch banks
                        bank_reg  <= ~bank_reg;
                        shift_reg <= new_shift_reg;
                        used_reg  <= live_reg;
                        state_reg <= ST_OUT;
                    end else begin
                        old_i_reg <= old_i_reg + CW'(1);
                        state_reg <= ST_RRD;
                    end
                end
                ST_RPRD: begin
                    state_reg <= ST_RPCK;
                end
                ST_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_data_reg   <= {11'(size), 11'(live_reg), res_status_reg,
                                         res_vout_reg, res_hit_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

endmodule
`default_nettype wire

// ----- design/oahm_checker.sv -----
// Port-level checker for the hash map, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "open_addressing_hash_map_assert.svh"
module oahm_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [oahm_pkg::M_DATA_W-1:0] m_tdata
);

    `OAHM_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result item dropped while stalled")
    `OAHM_ASSERT_NXT(a_one_item, aclk, aresetn, s_tvalid && s_tready, !s_tready, "second item taken while one is at work")
    `OAHM_ASSERT_IMP(a_full_cnt, aclk, aresetn, m_tvalid && m_tdata[oahm_pkg::M_STATUS_BIT], (m_tdata[oahm_pkg::M_CNT_HI:oahm_pkg::M_CNT_LO] == m_tdata[oahm_pkg::M_CAP_HI:oahm_pkg::M_CAP_LO]) && !m_tdata[oahm_pkg::M_HIT_BIT], "full flag without a full table")
    `OAHM_ASSERT_IMP(a_val_hit, aclk, aresetn, m_tvalid && (m_tdata[oahm_pkg::M_VAL_HI:oahm_pkg::M_VAL_LO] != 64'd0), m_tdata[oahm_pkg::M_HIT_BIT], "value returned on a miss")

endmodule

bind open_addressing_hash_map oahm_checker u_oahm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
